/* hdl/rope_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rope_pkg
// shared types and constants of the rotary embedding rotate unit
// ---------------------------------------------------------------------------
package rope_pkg;

	localparam int DATA_W         = 32;
	localparam int LEN_W          = 9;
	localparam int IDX_W          = 8;
	localparam int CFG_IDX_W      = 2;
	localparam int PROD_W         = 64;
	localparam int FRAC_SHIFT     = 30;
	localparam int ROT_W          = PROD_W - FRAC_SHIFT;
	localparam int SUM_W          = ROT_W + 1;
	localparam int MAX_LENGTH_DEF = 256;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(128);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAYOUT = 2'd0,
		REG_LENGTH = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] element_value;
		logic signed [DATA_W-1:0] sine;
		logic signed [DATA_W-1:0] cosine;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_index;
		logic signed [DATA_W-1:0] out_value;
		logic                     run_last;
		logic                     vector_done;
	} out_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx_re;
		logic [IDX_W-1:0] idx_im;
		logic             done;
	} pair_tag_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] re_in;
		logic signed [DATA_W-1:0] im_in;
		logic signed [DATA_W-1:0] sine;
		logic signed [DATA_W-1:0] cosine;
		pair_tag_t                tag;
	} rot_op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] re_out;
		logic signed [DATA_W-1:0] im_out;
		pair_tag_t                tag;
	} pair_t;

	typedef enum logic {
		OUT_REAL,
		OUT_IMAG
	} out_phase_t;

endpackage

/* hdl/rope_stream_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rope_stream_if
// valid/ready stream channel with a typed payload
// ---------------------------------------------------------------------------
interface rope_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/rope_hold_mem.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rope_hold_mem
// buffer for the first element of each pair with its sine and cosine
// ---------------------------------------------------------------------------
module rope_hold_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  rope_pkg::in_item_t wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output rope_pkg::in_item_t rdata
);
	import rope_pkg::*;

	in_item_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/rope_rotate_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rope_rotate_dp
// multiply, round and saturating sum of one pair rotation, three stages
// ---------------------------------------------------------------------------
module rope_rotate_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rope_pkg::rot_op_t in_op,
	output logic              in_ready,
	output logic              out_valid,
	output rope_pkg::pair_t   out_pair,
	input  logic              out_ready
);
	import rope_pkg::*;

	function automatic logic signed [ROT_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + (PROD_W'(1) <<< (FRAC_SHIFT - 1));
		return t[PROD_W-1:FRAC_SHIFT];
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
		lo = -hi - SUM_W'(1);
		if (v > hi) begin
			return hi[DATA_W-1:0];
		end else if (v < lo) begin
			return lo[DATA_W-1:0];
		end
		return v[DATA_W-1:0];
	endfunction

	logic signed [DATA_W-1:0] op_r, op_i, op_s, op_c;
	logic signed [PROD_W-1:0] prod_rc, prod_is, prod_rs, prod_ic;

	logic v_s2, v_s3, v_s4;
	logic rdy_s2, rdy_s3, rdy_s4;

	logic signed [PROD_W-1:0] p_rc_s2, p_is_s2, p_rs_s2, p_ic_s2;
	pair_tag_t                tag_s2, tag_s3, tag_s4;
	logic signed [ROT_W-1:0]  r_rc_s3, r_is_s3, r_rs_s3, r_ic_s3;
	logic signed [DATA_W-1:0] re_s4, im_s4;

	assign op_r = in_op.re_in;
	assign op_i = in_op.im_in;
	assign op_s = in_op.sine;
	assign op_c = in_op.cosine;

	assign prod_rc = op_r * op_c;
	assign prod_is = op_i * op_s;
	assign prod_rs = op_r * op_s;
	assign prod_ic = op_i * op_c;

	// bubbles collapse: a stage moves when it is empty or its successor moves
	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= in_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			p_rc_s2 <= prod_rc;
			p_is_s2 <= prod_is;
			p_rs_s2 <= prod_rs;
			p_ic_s2 <= prod_ic;
			tag_s2  <= in_op.tag;
		end
		if (rdy_s3 && v_s2) begin
			r_rc_s3 <= round_q30(p_rc_s2);
			r_is_s3 <= round_q30(p_is_s2);
			r_rs_s3 <= round_q30(p_rs_s2);
			r_ic_s3 <= round_q30(p_ic_s2);
			tag_s3  <= tag_s2;
		end
		if (rdy_s4 && v_s3) begin
			re_s4  <= sat32(SUM_W'(r_rc_s3) - SUM_W'(r_is_s3));
			im_s4  <= sat32(SUM_W'(r_rs_s3) + SUM_W'(r_ic_s3));
			tag_s4 <= tag_s3;
		end
	end

	assign out_valid       = v_s4;
	assign out_pair.re_out = re_s4;
	assign out_pair.im_out = im_s4;
	assign out_pair.tag    = tag_s4;

endmodule

/* hdl/rope_out_stage.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rope_out_stage
// output register that sends a rotated pair as two results, real first
// ---------------------------------------------------------------------------
module rope_out_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  rope_pkg::pair_t         in_pair,
	output logic                    in_ready,
	rope_stream_if.source           out_ch
);
	import rope_pkg::*;

	out_phase_t phase_q, phase_d;
	logic       valid_q, valid_d;
	pair_t      pair_q;
	logic       take;

	// free, or handing over the imaginary result this cycle
	assign take     = !valid_q || (phase_q == OUT_IMAG && out_ch.ready);
	assign in_ready = take;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			OUT_REAL: begin
				if (valid_q && out_ch.ready) begin
					phase_d = OUT_IMAG;
				end
			end
			OUT_IMAG: begin
				if (out_ch.ready) begin
					phase_d = OUT_REAL;
				end
			end
			default: phase_d = OUT_REAL;
		endcase
		valid_d = take ? in_valid : valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= OUT_REAL;
			valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			pair_q <= in_pair;
		end
	end

	always_comb begin
		out_ch.valid = valid_q;
		unique case (phase_q)
			OUT_IMAG: begin
				out_ch.data.out_index   = pair_q.tag.idx_im;
				out_ch.data.out_value   = pair_q.im_out;
				out_ch.data.run_last    = 1'b1;
				out_ch.data.vector_done = pair_q.tag.done;
			end
			default: begin
				out_ch.data.out_index   = pair_q.tag.idx_re;
				out_ch.data.out_value   = pair_q.re_out;
				out_ch.data.run_last    = 1'b0;
				out_ch.data.vector_done = 1'b0;
			end
		endcase
	end

	a_imag_has_pair: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == OUT_IMAG |-> valid_q)
		else $error("imaginary phase without a held pair");

	a_real_then_imag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_ch.ready && phase_q == OUT_REAL |=> valid_q && phase_q == OUT_IMAG)
		else $error("real result not followed by its imaginary result");

endmodule

/* hdl/rotary_embedding_rotate_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotary_embedding_rotate_unit
// rotary position embedding over a streamed vector, one element per request
// ---------------------------------------------------------------------------
// in_ch carries element_value with the sine and cosine of its pair; the angle
// is taken from the pair's first element. out_ch carries out_index, out_value,
// run_last (second result of a pair) and vector_done (last result of vector).
// cfg_we/cfg_index/cfg_data set layout_interleaved (0) and vector_length (1);
// either write restarts the vector. Write only while the unit is idle.
// While out_ch is ready, interleaved layout takes one element per cycle and
// gives one result per cycle; half-split layout takes the first half at one
// element per cycle into the hold memory, then one element per two results,
// as each completes a pair and out_ch carries one result per cycle.
// The real result of a pair comes out after the completing request passes
// s1, s2 to s4 and the output register; the imaginary result follows it.
// Reset: half-split layout, length 128, element count 0; the hold memory is
// not cleared. A stall on out_ch fills the pipeline, then deasserts
// in_ch.ready; nothing is dropped.
// ---------------------------------------------------------------------------
module rotary_embedding_rotate_unit #(
	parameter int MAX_LENGTH = rope_pkg::MAX_LENGTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rope_stream_if.sink                    in_ch,
	rope_stream_if.source                  out_ch,
	input  logic                           cfg_we,
	input  logic [rope_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rope_pkg::LEN_W-1:0]     cfg_data
);
	import rope_pkg::*;

	localparam int HOLD_DEPTH = MAX_LENGTH / 2;
	localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int CAP_EVEN   = MAX_LENGTH - (MAX_LENGTH % 2);
	localparam int LEN_TOP    = (2 ** LEN_W) - 2;
	localparam int CAP        = (CAP_EVEN < LEN_TOP) ? CAP_EVEN : LEN_TOP;

	logic             layout_q;
	logic [LEN_W-1:0] length_q;
	logic [LEN_W-1:0] cnt_q;

	logic [LEN_W-1:0] len_even, eff_len, cnt, k;
	logic [LEN_W-2:0] half;
	logic             done, emit, acc, s1_ready;

	logic [HOLD_AW-1:0] waddr, raddr;
	in_item_t           hold_rd;

	logic                     v_s1;
	logic signed [DATA_W-1:0] x_s1;
	pair_tag_t                tag_s1, tag_d;

	rot_op_t op_s1;
	logic    dp_ready, dp_valid, os_ready;
	pair_t   dp_pair;

	always_comb begin
		len_even = {length_q[LEN_W-1:1], 1'b0};
		eff_len  = len_even;
		if (len_even > LEN_W'(CAP)) begin
			eff_len = LEN_W'(CAP);
		end
		if (eff_len < LEN_W'(2)) begin
			eff_len = LEN_W'(2);
		end
		half = eff_len[LEN_W-1:1];
		cnt  = (cnt_q >= eff_len) ? '0 : cnt_q;
		done = (cnt + LEN_W'(1)) == eff_len;
		k    = cnt - {1'b0, half};
		if (layout_q) begin
			emit         = cnt[0];
			waddr        = '0;
			raddr        = '0;
			tag_d.idx_re = IDX_W'(cnt - LEN_W'(1));
		end else begin
			emit         = cnt >= {1'b0, half};
			waddr        = HOLD_AW'(cnt);
			raddr        = HOLD_AW'(k);
			tag_d.idx_re = IDX_W'(k);
		end
		tag_d.idx_im = IDX_W'(cnt);
		tag_d.done   = done;
	end

	assign s1_ready    = !v_s1 || dp_ready;
	assign in_ch.ready = s1_ready;
	assign acc         = in_ch.valid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= 1'b0;
			length_q <= LEN_RESET;
			cnt_q    <= '0;
		end else begin
			priority if (cfg_we && (cfg_index == REG_LAYOUT || cfg_index == REG_LENGTH)) begin
				if (cfg_index == REG_LAYOUT) begin
					layout_q <= cfg_data[0];
				end else begin
					length_q <= cfg_data;
				end
				cnt_q <= '0;
			end else if (acc) begin
				cnt_q <= done ? '0 : cnt + LEN_W'(1);
			end
		end
	end

	rope_hold_mem #(
		.DEPTH(HOLD_DEPTH),
		.AW   (HOLD_AW)
	) u_hold (
		.clk  (clk),
		.we   (acc && !emit),
		.waddr(waddr),
		.wdata(in_ch.data),
		.re   (acc && emit),
		.raddr(raddr),
		.rdata(hold_rd)
	);

	// s1 lines up with the registered memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_ready) begin
			v_s1 <= acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			x_s1   <= in_ch.data.element_value;
			tag_s1 <= tag_d;
		end
	end

	assign op_s1.re_in  = hold_rd.element_value;
	assign op_s1.im_in  = x_s1;
	assign op_s1.sine   = hold_rd.sine;
	assign op_s1.cosine = hold_rd.cosine;
	assign op_s1.tag    = tag_s1;

	rope_rotate_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_op    (op_s1),
		.in_ready (dp_ready),
		.out_valid(dp_valid),
		.out_pair (dp_pair),
		.out_ready(os_ready)
	);

	rope_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(dp_valid),
		.in_pair (dp_pair),
		.in_ready(os_ready),
		.out_ch  (out_ch)
	);

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < eff_len)
		else $error("element count beyond vector length");

	a_pair_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc && emit |=> v_s1)
		else $error("completed pair did not enter the first stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !dp_ready |=> v_s1 && $stable(x_s1) && $stable(hold_rd))
		else $error("stalled first stage lost its operands");

endmodule
